[rtl/wir_pkg.sv]
// Shared types for the wide integer remainder core.
`timescale 1ns / 1ps

package wir_pkg;

  typedef struct packed {
    logic [31:0] dividend_word;
    logic [31:0] divisor_word;
    logic        final_word;
  } wir_req_t;

  typedef struct packed {
    logic [31:0] remainder_word;
    logic        run_end;
  } wir_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LATCH,
    ST_CMP,
    ST_UPD,
    ST_EMIT
  } wir_state_e;

endpackage

[rtl/wir_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wir_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/wir_word_alu.sv]
// Word slice of the shift-and-subtract unit: shift one bit in, subtract with borrow.
`timescale 1ns / 1ps

module wir_word_alu (
  input  logic [31:0] rem_word_i,
  input  logic        shift_in_i,
  input  logic [31:0] dvs_word_i,
  input  logic        borrow_in_i,
  output logic [31:0] shifted_o,
  output logic        shift_out_o,
  output logic [31:0] diff_o,
  output logic        borrow_out_o
);

  logic [32:0] diff_full;

  assign shifted_o   = {rem_word_i[30:0], shift_in_i};
  assign shift_out_o = rem_word_i[31];
  assign diff_full   = {1'b0, shifted_o} - {1'b0, dvs_word_i} - {32'd0, borrow_in_i};
  assign diff_o       = diff_full[31:0];
  assign borrow_out_o = diff_full[32];

endmodule

[rtl/wide_integer_remainder_core.sv]
// Top level of the wide unsigned remainder core (restoring division, word serial).
`timescale 1ns / 1ps

// Run: a final request starts a run over 32*WORD_COUNT dividend bits. Each bit takes a
//   compare pass and an update pass over the words on the one 32-bit word ALU, each
//   dividend word is fetched through the FETCH and LATCH states, and an emit pass follows.
//   busy_o is high for the whole run; a non-final request only loads a word pair.
//   Throughput: one request at a time; no request is taken while busy_o is high.
// Reset clears the fill count and sequencer; stores need no clearing pass; no result stall.

module wide_integer_remainder_core #(
  parameter int WORD_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  wir_pkg::wir_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output wir_pkg::wir_res_t res_o
);

  import wir_pkg::*;

  // AW indexes a word, CW counts 0..WORD_COUNT, BW indexes a dividend bit.
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CW = $clog2(WORD_COUNT + 1);
  localparam int BW = AW + 5;
  localparam logic [BW-1:0] TopBit  = BW'(32 * WORD_COUNT - 1);
  localparam logic [CW-1:0] LastCnt = CW'(WORD_COUNT);

  wir_state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;     // words loaded in this run
  logic [CW-1:0] cnt_q, cnt_d;       // word pass counter, 0 issues the first read
  logic [BW-1:0] bit_q, bit_d;       // dividend bit being brought in
  logic [31:0]   dw_q, dw_d;         // current dividend word, top bit is next in
  logic          carry_q, carry_d;   // bit shifted out of the previous word
  logic          borrow_q, borrow_d; // borrow from the previous word
  logic          sub_q, sub_d;       // compare pass says subtract

  // Memory ports.
  logic          load_we;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] dvd_raddr;
  logic [AW-1:0] word_raddr;
  logic          rem_we;
  logic [AW-1:0] rem_waddr;
  logic [31:0]   rem_wdata;
  logic [31:0]   dvd_rdata, dvs_rdata, rem_rdata;

  // Word ALU.
  logic [31:0]   alu_rem, alu_dvs, alu_shifted, alu_diff;
  logic          alu_shift_in, alu_borrow_in, alu_shift_out, alu_borrow_out;

  logic [CW-1:0] proc_cnt;
  logic          proc_loaded;
  logic          dvd_loaded;
  logic          first_bit;
  logic          pass_end;
  logic          accept;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign proc_cnt    = cnt_q - CW'(1);
  assign proc_loaded = proc_cnt < fill_q;
  assign dvd_loaded  = CW'(bit_q[BW-1:5]) < fill_q;
  assign first_bit   = bit_q == TopBit;
  assign pass_end    = cnt_q == LastCnt;

  assign load_addr  = fill_q[AW-1:0];
  assign dvd_raddr  = bit_q[BW-1:5];
  assign word_raddr = cnt_q[AW-1:0];
  assign rem_waddr  = proc_cnt[AW-1:0];

  wir_ram #(.Width(32), .Depth(WORD_COUNT)) u_dvd_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (req_i.dividend_word),
    .raddr_i (dvd_raddr),
    .rdata_o (dvd_rdata)
  );

  wir_ram #(.Width(32), .Depth(WORD_COUNT)) u_dvs_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (req_i.divisor_word),
    .raddr_i (word_raddr),
    .rdata_o (dvs_rdata)
  );

  wir_ram #(.Width(32), .Depth(WORD_COUNT)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (word_raddr),
    .rdata_o (rem_rdata)
  );

  // Unloaded divisor words read as zero; the remainder starts at zero on the first bit.
  assign alu_rem       = first_bit ? 32'd0 : rem_rdata;
  assign alu_dvs       = proc_loaded ? dvs_rdata : 32'd0;
  assign alu_shift_in  = (cnt_q == CW'(1)) ? dw_q[31] : carry_q;
  assign alu_borrow_in = (cnt_q == CW'(1)) ? 1'b0 : borrow_q;

  wir_word_alu u_alu (
    .rem_word_i   (alu_rem),
    .shift_in_i   (alu_shift_in),
    .dvs_word_i   (alu_dvs),
    .borrow_in_i  (alu_borrow_in),
    .shifted_o    (alu_shifted),
    .shift_out_o  (alu_shift_out),
    .diff_o       (alu_diff),
    .borrow_out_o (alu_borrow_out)
  );

  assign rem_wdata = sub_q ? alu_diff : alu_shifted;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.final_word) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_LATCH;
      ST_LATCH: state_d = ST_CMP;
      ST_CMP: begin
        if (pass_end) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (pass_end) begin
          if (bit_q == '0) begin
            state_d = ST_EMIT;
          end else if (bit_q[4:0] == 5'd0) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_EMIT: begin
        if (pass_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    dw_d        = dw_q;
    carry_d     = carry_q;
    borrow_d    = borrow_q;
    sub_d       = sub_q;
    load_we     = 1'b0;
    rem_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o.remainder_word = rem_rdata;
    res_o.run_end        = pass_end;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        bit_d = TopBit;
        // Drop pairs beyond capacity; a final mark still starts the run.
        if (accept && (fill_q < LastCnt)) begin
          load_we = 1'b1;
          fill_d  = fill_q + CW'(1);
        end
      end
      ST_FETCH: begin
        cnt_d = '0;
      end
      ST_LATCH: begin
        dw_d = dvd_loaded ? dvd_rdata : 32'd0;
      end
      ST_CMP: begin
        cnt_d = pass_end ? '0 : cnt_q + CW'(1);
        if (cnt_q != '0) begin
          carry_d  = alu_shift_out;
          borrow_d = alu_borrow_out;
          if (pass_end) sub_d = alu_shift_out | ~alu_borrow_out;
        end
      end
      ST_UPD: begin
        cnt_d = pass_end ? '0 : cnt_q + CW'(1);
        if (cnt_q != '0) begin
          rem_we   = 1'b1;
          carry_d  = alu_shift_out;
          borrow_d = alu_borrow_out;
        end
        if (pass_end && (bit_q != '0)) begin
          bit_d = bit_q - BW'(1);
          dw_d  = {dw_q[30:0], 1'b0};
        end
      end
      ST_EMIT: begin
        cnt_d = pass_end ? '0 : cnt_q + CW'(1);
        res_valid_o = cnt_q != '0;
        // Clear the load stores by rewinding the fill count.
        if (pass_end) fill_d = '0;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      bit_q   <= TopBit;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw_q     <= dw_d;
    carry_q  <= carry_d;
    borrow_q <= borrow_d;
    sub_q    <= sub_d;
  end

endmodule
